>>> rtl/core/dirent_stream_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// Directory stream parser assertion macros
// Assertion helpers sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DIRENT_STREAM_PARSER_UNIT_DEFINES_SVH
`define DIRENT_STREAM_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define DSP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dsp assertion failed");
`define DSP_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("dsp forbidden condition");
`else
`define DSP_ASSERT(name, prop)
`define DSP_ASSERT_NEVER(name, cond)
`endif

`endif

>>> rtl/core/dsp_pkg.sv
// ----------------------------------------------------------------------------
// Directory stream parser package
// Record layout constants, mode codes and the entry request type.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam logic [4:0] HdrLen     = 5'd24;
  localparam logic [4:0] PosQidType = 5'd0;
  localparam logic [4:0] PosOffLo   = 5'd13;
  localparam logic [4:0] PosOffHi   = 5'd20;
  localparam logic [4:0] PosLenLo   = 5'd22;
  localparam logic [4:0] PosLenHi   = 5'd23;

  localparam int unsigned QidDirBit = 7;
  localparam logic [7:0]  DotChar   = 8'h2E;

  localparam logic [15:0] ModeDir  = 16'h41ED;
  localparam logic [15:0] ModeFile = 16'h81A4;

  localparam int unsigned LenW      = 6;
  localparam int unsigned EntryNumW = 10;
  localparam int unsigned CountW    = 11;

  typedef struct packed {
    logic [LenW-1:0]      name_len;
    logic                 is_dir;
    logic [63:0]          offset;
    logic [EntryNumW-1:0] entry_num;
  } entry_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/core/dsp_front.sv
// ----------------------------------------------------------------------------
// Directory stream parser front end
// Walks record headers, stores name bytes, decides which records are kept.
// ----------------------------------------------------------------------------
module dsp_front #(
  parameter int unsigned NAME_BYTES  = 32,
  parameter int unsigned ENTRY_LIMIT = 1024,
  parameter int unsigned IdxW        = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    body_byte_i,
  input  logic                          body_last_i,
  input  logic                          listing_start_i,
  input  logic                          cfg_we_i,
  input  logic [dsp_pkg::CountW-1:0]    cfg_wdata_i,
  input  dsp_pkg::q_status_t            q_stat_i,
  output logic                          push_o,
  output dsp_pkg::entry_desc_t          push_desc_o,
  output logic                          wr_en_o,
  output logic [IdxW-1:0]               wr_idx_o,
  output logic [7:0]                    wr_data_o
);

  localparam int unsigned Depth = NAME_BYTES - 1;
  localparam logic [15:0] DepthW = Depth[15:0];
  localparam logic [dsp_pkg::LenW-1:0] DepthLen = Depth[dsp_pkg::LenW-1:0];
  localparam logic [15:0] LimitW = ENTRY_LIMIT[15:0];

  logic [4:0]                  hp_q, hp_d;
  logic [15:0]                 nbs_q, nbs_d;
  logic [7:0]                  qtype_q, qtype_d;
  logic [63:0]                 off_q, off_d;
  logic [15:0]                 nlen_q, nlen_d;
  logic [dsp_pkg::CountW-1:0]  cnt_q, cnt_d;
  logic                        full_q, full_d;
  logic                        dots_q, dots_d;
  logic [dsp_pkg::CountW-1:0]  max_q;

  logic        accept;
  logic        finish;
  logic        is_dot;
  logic [15:0] lim;
  logic [2:0]  off_sel;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i & ~q_stat_i.full;
  assign lim        = ({5'b0, max_q} > LimitW) ? LimitW : {5'b0, max_q};
  assign off_sel    = 3'(hp_q - dsp_pkg::PosOffLo);
  assign wr_data_o  = body_byte_i;

  always_comb begin
    hp_d        = hp_q;
    nbs_d       = nbs_q;
    qtype_d     = qtype_q;
    off_d       = off_q;
    nlen_d      = nlen_q;
    cnt_d       = cnt_q;
    full_d      = full_q;
    dots_d      = dots_q;
    finish      = 1'b0;
    is_dot      = 1'b0;
    push_o      = 1'b0;
    wr_en_o     = 1'b0;
    wr_idx_o    = nbs_q[IdxW-1:0];
    push_desc_o = '0;
    if (accept) begin
      if (listing_start_i) begin
        cnt_d  = '0;
        full_d = 1'b0;
        hp_d   = '0;
        nbs_d  = '0;
        dots_d = 1'b0;
      end
      if (hp_d < dsp_pkg::HdrLen) begin
        if (hp_d == dsp_pkg::PosQidType) begin
          qtype_d = body_byte_i;
        end else if (hp_d >= dsp_pkg::PosOffLo && hp_d <= dsp_pkg::PosOffHi) begin
          off_d[{off_sel, 3'b000} +: 8] = body_byte_i;
        end else if (hp_d == dsp_pkg::PosLenLo) begin
          nlen_d = {8'h00, body_byte_i};
        end else if (hp_d == dsp_pkg::PosLenHi) begin
          nlen_d = {body_byte_i, nlen_q[7:0]};
        end
        hp_d = hp_d + 5'd1;
        if (hp_d == dsp_pkg::HdrLen) begin
          nbs_d  = '0;
          dots_d = 1'b0;
          finish = (nlen_d == 16'd0);
        end
      end else begin
        wr_idx_o = nbs_d[IdxW-1:0];
        wr_en_o  = (nbs_d < DepthW);
        dots_d   = ((nbs_d == 16'd0) || dots_d) && (body_byte_i == dsp_pkg::DotChar);
        nbs_d    = nbs_d + 16'd1;
        finish   = (nbs_d == nlen_d);
      end
      if (finish) begin
        is_dot = dots_d && ((nlen_d == 16'd1) || (nlen_d == 16'd2));
        hp_d   = '0;
        nbs_d  = '0;
        dots_d = 1'b0;
        if (!is_dot) begin
          if (full_d || ({5'b0, cnt_d} >= lim)) begin
            full_d = 1'b1;
          end else begin
            push_o                = 1'b1;
            push_desc_o.name_len  = (nlen_d < DepthW) ? nlen_d[dsp_pkg::LenW-1:0] : DepthLen;
            push_desc_o.is_dir    = qtype_q[dsp_pkg::QidDirBit];
            push_desc_o.offset    = off_d;
            push_desc_o.entry_num = cnt_d[dsp_pkg::EntryNumW-1:0];
            cnt_d                 = cnt_d + 11'd1;
            if ({5'b0, cnt_d} >= lim) begin
              full_d = 1'b1;
            end
          end
        end
      end
      if (body_last_i) begin
        hp_d   = '0;
        nbs_d  = '0;
        dots_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q    <= '0;
      nbs_q   <= '0;
      qtype_q <= '0;
      off_q   <= '0;
      nlen_q  <= '0;
      cnt_q   <= '0;
      full_q  <= 1'b0;
      dots_q  <= 1'b0;
      max_q   <= 11'd64;
    end else begin
      hp_q    <= hp_d;
      nbs_q   <= nbs_d;
      qtype_q <= qtype_d;
      off_q   <= off_d;
      nlen_q  <= nlen_d;
      cnt_q   <= cnt_d;
      full_q  <= full_d;
      dots_q  <= dots_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

>>> rtl/core/dsp_queue.sv
// ----------------------------------------------------------------------------
// Directory stream parser entry queue
// Two-slot queue of entry requests, each slot with its own name buffer.
// ----------------------------------------------------------------------------
`include "dirent_stream_parser_unit_defines.svh"

module dsp_queue #(
  parameter int unsigned IdxW = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dsp_pkg::entry_desc_t  push_desc_i,
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_idx_i,
  input  logic [7:0]            wr_data_i,
  input  logic                  pop_i,
  output dsp_pkg::entry_desc_t  head_desc_o,
  output dsp_pkg::q_status_t    stat_o,
  input  logic                  rd_en_i,
  input  logic [IdxW-1:0]       rd_idx_i,
  output logic [7:0]            rd_data_o
);

  localparam int unsigned MemEntries = 2 << IdxW;

  dsp_pkg::entry_desc_t desc_q [2];
  logic                 wptr_q, rptr_q;
  logic [1:0]           cnt_q;
  logic [7:0]           mem_q [MemEntries];
  logic [7:0]           rdata_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign head_desc_o  = desc_q[rptr_q];
  assign rd_data_o    = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      desc_q[wptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[{wptr_q, wr_idx_i}] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[{rptr_q, rd_idx_i}];
    end
  end

  `DSP_ASSERT_NEVER(a_push_when_full, push_i && stat_o.full)
  `DSP_ASSERT_NEVER(a_pop_when_empty, pop_i && stat_o.empty)
  `DSP_ASSERT_NEVER(a_cnt_range, cnt_q == 2'd3)
  `DSP_ASSERT(a_push_fills, (push_i && !pop_i) |=> (cnt_q != 2'd0))

endmodule

>>> rtl/core/dsp_back.sv
// ----------------------------------------------------------------------------
// Directory stream parser emitter
// Reads queued entries; one request per stored name character, one if none.
// ----------------------------------------------------------------------------
module dsp_back #(
  parameter int unsigned IdxW = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dsp_pkg::q_status_t             q_stat_i,
  input  dsp_pkg::entry_desc_t           head_desc_i,
  output logic                           pop_o,
  output logic                           rd_en_o,
  output logic [IdxW-1:0]                rd_idx_o,
  input  logic [7:0]                     rd_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     name_byte_o,
  output logic [4:0]                     char_index_o,
  output logic [4:0]                     name_length_o,
  output logic                           has_name_o,
  output logic                           is_dir_o,
  output logic [15:0]                    mode_o,
  output logic [63:0]                    entry_offset_o,
  output logic [dsp_pkg::EntryNumW-1:0]  entry_number_o,
  output logic                           last_of_entry_o
);

  logic [dsp_pkg::LenW-1:0] idx_q, idx_d, idx_nx, total;
  logic                     out_valid_q;
  logic                     adv, take;

  logic [4:0]                    cidx_q, nlen_q;
  logic                          has_q, dir_q, last_q;
  logic [63:0]                   off_q;
  logic [dsp_pkg::EntryNumW-1:0] num_q;

  assign adv      = ~out_valid_q | ~out_stall_i;
  assign take     = adv & ~q_stat_i.empty;
  assign total    = (head_desc_i.name_len == '0) ? 6'd1 : head_desc_i.name_len;
  assign idx_nx   = idx_q + 6'd1;
  assign pop_o    = take & (idx_nx == total);
  assign rd_en_o  = take;
  assign rd_idx_o = idx_q[IdxW-1:0];

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = pop_o ? '0 : idx_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (adv) begin
        out_valid_q <= take;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cidx_q <= idx_q[4:0];
      nlen_q <= head_desc_i.name_len[4:0];
      has_q  <= (head_desc_i.name_len != '0);
      dir_q  <= head_desc_i.is_dir;
      off_q  <= head_desc_i.offset;
      num_q  <= head_desc_i.entry_num;
      last_q <= (idx_nx == total);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign name_byte_o     = has_q ? rd_data_i : 8'h00;
  assign char_index_o    = cidx_q;
  assign name_length_o   = nlen_q;
  assign has_name_o      = has_q;
  assign is_dir_o        = dir_q;
  assign mode_o          = dir_q ? dsp_pkg::ModeDir : dsp_pkg::ModeFile;
  assign entry_offset_o  = off_q;
  assign entry_number_o  = num_q;
  assign last_of_entry_o = last_q;

endmodule

>>> rtl/core/dirent_stream_parser_unit.sv
// Timing: an entry is queued as its last body byte is accepted; its first
// request is then registered, or later while earlier entries are being sent.
// Throughput: one body byte per cycle in; one name character per cycle out
// while out_stall_i is low. Input stalls only while both queue slots are full.
// Reset: parser, counters and queue cleared, max_entries back to 64;
// name buffers are not cleared (only written slots are ever read).
// ----------------------------------------------------------------------------
// Directory stream parser top level
// Parses directory-read reply bodies into per-character name requests.
// ----------------------------------------------------------------------------
module dirent_stream_parser_unit #(
  parameter int unsigned NAME_BYTES  = 32,
  parameter int unsigned ENTRY_LIMIT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     body_byte_i,
  input  logic                           body_last_i,
  input  logic                           listing_start_i,
  input  logic                           cfg_we_i,
  input  logic [dsp_pkg::CountW-1:0]     cfg_wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     name_byte_o,
  output logic [4:0]                     char_index_o,
  output logic [4:0]                     name_length_o,
  output logic                           has_name_o,
  output logic                           is_dir_o,
  output logic [15:0]                    mode_o,
  output logic [63:0]                    entry_offset_o,
  output logic [dsp_pkg::EntryNumW-1:0]  entry_number_o,
  output logic                           last_of_entry_o
);

  localparam int unsigned IdxW = (NAME_BYTES > 2) ? $clog2(NAME_BYTES - 1) : 1;

  dsp_pkg::q_status_t   q_stat;
  dsp_pkg::entry_desc_t push_desc, head_desc;
  logic                 push, pop, wr_en, rd_en;
  logic [IdxW-1:0]      wr_idx, rd_idx;
  logic [7:0]           wr_data, rd_data;

  dsp_front #(
    .NAME_BYTES  (NAME_BYTES),
    .ENTRY_LIMIT (ENTRY_LIMIT),
    .IdxW        (IdxW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .body_byte_i     (body_byte_i),
    .body_last_i     (body_last_i),
    .listing_start_i (listing_start_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .push_desc_o     (push_desc),
    .wr_en_o         (wr_en),
    .wr_idx_o        (wr_idx),
    .wr_data_o       (wr_data)
  );

  dsp_queue #(
    .IdxW (IdxW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .wr_en_i     (wr_en),
    .wr_idx_i    (wr_idx),
    .wr_data_i   (wr_data),
    .pop_i       (pop),
    .head_desc_o (head_desc),
    .stat_o      (q_stat),
    .rd_en_i     (rd_en),
    .rd_idx_i    (rd_idx),
    .rd_data_o   (rd_data)
  );

  dsp_back #(
    .IdxW (IdxW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_stat_i        (q_stat),
    .head_desc_i     (head_desc),
    .pop_o           (pop),
    .rd_en_o         (rd_en),
    .rd_idx_o        (rd_idx),
    .rd_data_i       (rd_data),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .name_byte_o     (name_byte_o),
    .char_index_o    (char_index_o),
    .name_length_o   (name_length_o),
    .has_name_o      (has_name_o),
    .is_dir_o        (is_dir_o),
    .mode_o          (mode_o),
    .entry_offset_o  (entry_offset_o),
    .entry_number_o  (entry_number_o),
    .last_of_entry_o (last_of_entry_o)
  );

endmodule

>>> bench/dirent_stream_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// Directory stream parser testbench
// Feeds directory-read reply bodies byte by byte, with random gaps and output
// stalls, under several entry limits. A built-in parser predicts the name
// requests of each kept entry and checks them in order.
// ----------------------------------------------------------------------------
module dirent_stream_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NameBytes  = 32;
  localparam int unsigned EntryLimit = 1024;
  localparam int unsigned StoreDepth = NameBytes - 1;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned PhaseBytes = 20;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0]                    name_byte;
    logic [4:0]                    char_index;
    logic [4:0]                    name_length;
    logic                          has_name;
    logic                          is_dir;
    logic [15:0]                   mode;
    logic [63:0]                   entry_offset;
    logic [dsp_pkg::EntryNumW-1:0] entry_number;
    logic                          last_of_entry;
  } name_req_t;

  // Parser shadow: header walk, name capture and the listing entry budget.
  class dirent_book;
    bit [dsp_pkg::CountW-1:0] max_entries = 11'd64;
    bit [4:0]                 hdr_pos;
    bit [15:0]                seen;
    bit [7:0]                 qid_type;
    bit [63:0]                offset;
    bit [15:0]                name_len;
    bit [7:0]                 name_buf [StoreDepth];
    bit [dsp_pkg::CountW-1:0] count;
    bit                       full;
    bit                       dots;
    name_req_t                owed[$];
    int                       errors;

    function void close_record();
      bit          dot;
      bit          dir;
      int unsigned lim;
      int unsigned copy;
      int unsigned total;
      name_req_t   r;
      dot = dots && (name_len == 16'd1 || name_len == 16'd2);
      lim = (max_entries > EntryLimit) ? EntryLimit : int'(max_entries);
      hdr_pos = '0;
      seen = '0;
      dots = 1'b0;
      if (dot) return;
      if (full || count >= lim) begin
        full = 1'b1;
        return;
      end
      copy = (name_len < StoreDepth) ? int'(name_len) : StoreDepth;
      total = (copy == 0) ? 1 : copy;
      dir = qid_type[dsp_pkg::QidDirBit];
      for (int i = 0; i < total; i++) begin
        r.name_byte     = (copy == 0) ? 8'h00 : name_buf[i];
        r.char_index    = 5'(i);
        r.name_length   = 5'(copy);
        r.has_name      = (copy != 0);
        r.is_dir        = dir;
        r.mode          = dir ? dsp_pkg::ModeDir : dsp_pkg::ModeFile;
        r.entry_offset  = offset;
        r.entry_number  = count[dsp_pkg::EntryNumW-1:0];
        r.last_of_entry = (i + 1 == total);
        owed.push_back(r);
      end
      count = count + 1'b1;
      if (count >= lim) full = 1'b1;
    endfunction

    function void note_request(logic [7:0] b, logic last, logic start);
      int sh;
      if (start) begin
        count = '0;
        full = 1'b0;
        hdr_pos = '0;
        seen = '0;
        dots = 1'b0;
      end
      if (hdr_pos < dsp_pkg::HdrLen) begin
        if (hdr_pos == dsp_pkg::PosQidType) begin
          qid_type = b;
        end else if (hdr_pos >= dsp_pkg::PosOffLo && hdr_pos <= dsp_pkg::PosOffHi) begin
          sh = (int'(hdr_pos) - int'(dsp_pkg::PosOffLo)) * 8;
          offset[sh +: 8] = b;
        end else if (hdr_pos == dsp_pkg::PosLenLo) begin
          name_len = {8'h00, b};
        end else if (hdr_pos == dsp_pkg::PosLenHi) begin
          name_len[15:8] = b;
        end
        hdr_pos = hdr_pos + 1'b1;
        if (hdr_pos == dsp_pkg::HdrLen) begin
          seen = '0;
          dots = 1'b0;
          if (name_len == 16'd0) close_record();
        end
      end else begin
        if (seen < StoreDepth) name_buf[seen] = b;
        dots = (seen == 16'd0 || dots) && b == dsp_pkg::DotChar;
        seen = seen + 1'b1;
        if (seen == name_len) close_record();
      end
      if (last) begin
        hdr_pos = '0;
        seen = '0;
        dots = 1'b0;
      end
    endfunction

    function void cmp(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_request(name_req_t got);
      name_req_t want;
      if (owed.size() == 0) begin
        $error("name request with nothing expected: entry %0d index %0d",
               got.entry_number, got.char_index);
        errors++;
        return;
      end
      want = owed.pop_front();
      cmp("name_byte", want.name_byte, got.name_byte);
      cmp("char_index", want.char_index, got.char_index);
      cmp("name_length", want.name_length, got.name_length);
      cmp("has_name", want.has_name, got.has_name);
      cmp("is_dir", want.is_dir, got.is_dir);
      cmp("mode", want.mode, got.mode);
      cmp("entry_offset", want.entry_offset, got.entry_offset);
      cmp("entry_number", want.entry_number, got.entry_number);
      cmp("last_of_entry", want.last_of_entry, got.last_of_entry);
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [7:0]                    body_byte_i;
  logic                          body_last_i;
  logic                          listing_start_i;
  logic                          cfg_we_i;
  logic [dsp_pkg::CountW-1:0]    cfg_wdata_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [7:0]                    name_byte_o;
  logic [4:0]                    char_index_o;
  logic [4:0]                    name_length_o;
  logic                          has_name_o;
  logic                          is_dir_o;
  logic [15:0]                   mode_o;
  logic [63:0]                   entry_offset_o;
  logic [dsp_pkg::EntryNumW-1:0] entry_number_o;
  logic                          last_of_entry_o;

  dirent_book book;
  bit         calm;
  bit         restart_next;
  int         body_bytes;
  int         quiet = 0;

  dirent_stream_parser_unit #(
    .NAME_BYTES (NameBytes),
    .ENTRY_LIMIT(EntryLimit)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .body_byte_i    (body_byte_i),
    .body_last_i    (body_last_i),
    .listing_start_i(listing_start_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .name_byte_o    (name_byte_o),
    .char_index_o   (char_index_o),
    .name_length_o  (name_length_o),
    .has_name_o     (has_name_o),
    .is_dir_o       (is_dir_o),
    .mode_o         (mode_o),
    .entry_offset_o (entry_offset_o),
    .entry_number_o (entry_number_o),
    .last_of_entry_o(last_of_entry_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic byte_q_t make_name(int n, int dot_pct);
    byte_q_t q;
    for (int i = 0; i < n; i++) begin
      q.push_back(($urandom_range(0, 99) < dot_pct) ? dsp_pkg::DotChar
                                                    : 8'($urandom_range(0, 255)));
    end
    return q;
  endfunction

  task automatic push_body_byte(input logic [7:0] b, input logic last, input logic start);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    body_byte_i     <= b;
    body_last_i     <= last;
    listing_start_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    book.note_request(b, last, start);
  endtask

  // cut >= 0 stops the record after that byte, with or without body_last
  task automatic push_record(input logic [7:0] qt, input logic [63:0] off,
                             input logic [15:0] len_field, input byte_q_t nm,
                             input bit start, input bit tail, input int cut,
                             input bit cut_last);
    byte_q_t rec;
    int      stop;
    rec.push_back(qt);
    repeat (12) rec.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < 8; i++) rec.push_back(off[i*8 +: 8]);
    rec.push_back(8'($urandom_range(0, 255)));
    rec.push_back(len_field[7:0]);
    rec.push_back(len_field[15:8]);
    foreach (nm[i]) rec.push_back(nm[i]);
    stop = (cut >= 0 && cut < rec.size()) ? cut : rec.size() - 1;
    for (int i = 0; i <= stop; i++) begin
      push_body_byte(rec[i], (i == stop) && ((cut >= 0) ? cut_last : tail),
                     start && (i == 0));
    end
    body_bytes += stop + 1;
  endtask

  task automatic push_random_record(input bit start);
    logic [7:0]  qt;
    logic [63:0] off;
    byte_q_t     nm;
    int          r;
    int          cut;
    bit          cut_last;
    r  = $urandom_range(0, 99);
    qt = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       off = '0;
      1:       off = '1;
      default: off = {$urandom(), $urandom()};
    endcase
    if (r < 8) nm = make_name(0, 0);
    else if (r < 22) nm = make_name($urandom_range(1, 3), 85);
    else if (r < 88) nm = make_name($urandom_range(1, 12), 10);
    else nm = make_name($urandom_range(20, 40), 5);
    cut = -1;
    cut_last = 1'b1;
    if ($urandom_range(0, 99) < 12) begin
      cut = $urandom_range(0, 23 + nm.size());
      cut_last = ($urandom_range(0, 2) != 0);
    end
    push_record(qt, off, 16'(nm.size()), nm, start, $urandom_range(0, 99) < 30, cut,
                cut_last);
    restart_next = (cut >= 0) && !cut_last;
  endtask

  task automatic push_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 1; i <= n; i++) push_body_byte(8'($urandom_range(0, 255)), i == n, 1'b0);
  endtask

  task automatic set_max_entries(input logic [dsp_pkg::CountW-1:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (book.owed.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    book.max_entries = v;
  endtask

  initial begin
    int unsigned     out_hold;
    int unsigned     out_run;
    out_stall_i = 1'b0;
    forever begin
      out_hold = pick_gap();
      out_run  = $urandom_range(1, 12);
      if (out_hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (out_hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat (out_run) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : watch_requests
    name_req_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.name_byte     = name_byte_o;
      got.char_index    = char_index_o;
      got.name_length   = name_length_o;
      got.has_name      = has_name_o;
      got.is_dir        = is_dir_o;
      got.mode          = mode_o;
      got.entry_offset  = entry_offset_o;
      got.entry_number  = entry_number_o;
      got.last_of_entry = last_of_entry_o;
      book.check_request(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    byte_q_t                  nm;
    int                       base;
    bit                       first;
    logic [dsp_pkg::CountW-1:0] limits [5];
    limits = '{11'd64, 11'd1, 11'd0, 11'd2047, 11'd2};
    book            = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    body_byte_i     = '0;
    body_last_i     = 1'b0;
    listing_start_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    calm            = 1'b0;
    restart_next    = 1'b0;
    body_bytes      = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: dot names, empty and long names, dropped and abandoned records
    nm = '{8'h61};
    push_record(8'h00, 64'h0, 16'd1, nm, 1'b1, 1'b0, -1, 1'b0);
    nm.delete();
    push_record(8'h80, '1, 16'd0, nm, 1'b0, 1'b0, -1, 1'b0);
    nm = '{dsp_pkg::DotChar};
    push_record(8'h80, 64'h10, 16'd1, nm, 1'b0, 1'b0, -1, 1'b0);
    nm = '{dsp_pkg::DotChar, dsp_pkg::DotChar};
    push_record(8'h80, 64'h20, 16'd2, nm, 1'b0, 1'b0, -1, 1'b0);
    nm = make_name(40, 0);
    nm[0] = 8'h00;
    nm[1] = 8'hFF;
    push_record(8'h80, 64'h8000_0000_0000_0001, 16'd40, nm, 1'b0, 1'b0, -1, 1'b0);
    nm = make_name(31, 10);
    push_record(8'h00, 64'h7FFF_FFFF_FFFF_FFFF, 16'd31, nm, 1'b0, 1'b1, -1, 1'b0);
    nm = make_name(5, 0);
    push_record(8'hC3, 64'h55, 16'hFFFF, nm, 1'b0, 1'b1, -1, 1'b0);
    nm = make_name(4, 0);
    push_record(8'h80, 64'h66, 16'd4, nm, 1'b0, 1'b0, 10, 1'b1);
    nm = make_name(6, 0);
    push_record(8'h80, 64'h77, 16'd6, nm, 1'b0, 1'b0, 26, 1'b0);
    nm = '{8'h62};
    push_record(8'h00, 64'h88, 16'd1, nm, 1'b1, 1'b0, -1, 1'b0);

    // random listings, a phase per entry limit
    for (int p = 0; p < 5; p++) begin
      if (p > 0) set_max_entries(limits[p]);
      calm  = (p == 3);
      base  = body_bytes;
      first = 1'b1;
      while (body_bytes - base < PhaseBytes) begin
        if (!first && $urandom_range(0, 99) < 5) push_noise();
        push_random_record(first || restart_next || $urandom_range(0, 99) < 4);
        first = 1'b0;
      end
    end
    calm = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (book.owed.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
